// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the controller and datapath files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression holds on every rising clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_HOLDS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/coo2csr_pkg.sv =====
`timescale 1ns / 1ps

package coo2csr_pkg;

   // command codes on req_command
   typedef enum logic [2:0] {
      CMD_CLEAR    = 3'd0,
      CMD_COUNT    = 3'd1,
      CMD_FINALIZE = 3'd2,
      CMD_PLACE    = 3'd3,
      CMD_READ     = 3'd4
   } cmd_code_type;

   // controller states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_WALK,
      ST_EXEC
   } state_type;

   // capacity of the compressed arrays
   localparam int unsigned NNZ_MAX = 32'd65536;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic sweep;
      logic walk;
      logic exec;
      logic finish;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic sweep_last;
      logic walk_done;
   } sts_type;

endpackage

// ===== hw/rtl/coo2csr_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module coo2csr_ctrl import coo2csr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [2:0] req_command,
   input  sts_type    sts,
   output ctl_type    ctl,
   output logic       busy
);

   state_type state_ff;
   state_type state_in;
   logic [3:0] step_vec;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         ST_INIT: begin
            ctl.sweep = 1'b1;
            if (sts.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               ctl.accept = 1'b1;
               case (req_command)
                  CMD_CLEAR:    state_in = ST_CLEAR;
                  CMD_FINALIZE: state_in = ST_WALK;
                  default:      state_in = ST_EXEC;
               endcase
            end
         end
         ST_CLEAR: begin
            ctl.sweep = 1'b1;
            if (sts.sweep_last) begin
               ctl.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_WALK: begin
            ctl.walk = 1'b1;
            if (sts.walk_done) begin
               ctl.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_EXEC: begin
            ctl.exec = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   assign busy     = (state_ff != ST_IDLE);
   assign step_vec = {ctl.accept, ctl.sweep, ctl.walk, ctl.exec};

   // checks
   `ASSERT_HOLDS(a_one_step, clock, reset, $onehot0(step_vec))
   `ASSERT_NEXT(a_finish_idle, clock, reset, ctl.finish, state_ff == ST_IDLE)
   `ASSERT_NEXT(a_accept_busy, clock, reset, ctl.accept, busy)

endmodule

// ===== hw/rtl/coo2csr_datapath.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module coo2csr_datapath import coo2csr_pkg::*; #(
   parameter int ROWS_MAX = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  ctl_type     ctl,
   output sts_type     sts,
   input  logic [2:0]  req_command,
   input  logic [9:0]  req_row,
   input  logic [30:0] req_col,
   input  logic [31:0] req_value,
   input  logic [10:0] req_pointer_index,
   output logic        rsp_valid,
   output logic [15:0] rsp_dest_slot,
   output logic [30:0] rsp_col_out,
   output logic [31:0] rsp_value_out,
   output logic [16:0] rsp_row_pointer,
   output logic        rsp_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_num_rows
);

   localparam int AW = $clog2(ROWS_MAX + 1);
   localparam int CW = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
   localparam logic [16:0] ROWS_MAX_W = 17'(ROWS_MAX);
   localparam logic [10:0] ROWS_RESET = (ROWS_MAX < 1024) ? 11'(ROWS_MAX) : 11'd1024;

   // row table and per-row cursors
   logic [16:0] row_mem [0:ROWS_MAX];
   logic [16:0] cur_mem [0:ROWS_MAX-1];

   logic [AW-1:0] rt_raddr;
   logic [AW-1:0] rt_waddr;
   logic [16:0]   rt_wdata;
   logic          rt_we;
   logic [16:0]   rt_rdata_ff;
   logic [CW-1:0] cur_raddr;
   logic [CW-1:0] cur_waddr;
   logic [16:0]   cur_wdata;
   logic          cur_we;
   logic [16:0]   cur_rdata_ff;

   // control registers
   logic [10:0]   rows_ff, rows_in;
   logic [16:0]   total_ff, total_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          pv_ff, pv_in;
   logic          rsp_valid_ff;

   // payload registers
   logic [AW-1:0] pk_ff;
   logic [16:0]   acc_ff, acc_in;
   logic [2:0]    cmd_ff;
   logic [9:0]    row_ff;
   logic [30:0]   col_ff;
   logic [31:0]   val_ff;
   logic [10:0]   pidx_ff;
   logic [15:0]   slot_ff;
   logic [30:0]   cout_ff;
   logic [31:0]   vout_ff;
   logic [16:0]   ptr_ff;
   logic          err_ff;

   // result of the current command
   logic [15:0] slot_in;
   logic [30:0] cout_in;
   logic [31:0] vout_in;
   logic [16:0] ptr_in;
   logic        err_in;

   logic        row_ok;
   logic        total_full;
   logic        dest_ok;
   logic        pidx_ok;
   logic        count_ok;
   logic        place_ok;
   logic [16:0] walk_sum;
   logic        respond;

   // memory ports
   always_ff @(posedge clock) begin
      if (rt_we) begin
         row_mem[rt_waddr] <= rt_wdata;
      end
      rt_rdata_ff <= row_mem[rt_raddr];
   end

   always_ff @(posedge clock) begin
      if (cur_we) begin
         cur_mem[cur_waddr] <= cur_wdata;
      end
      cur_rdata_ff <= cur_mem[cur_raddr];
   end

   // read addresses come from the request, but from the walk index during the walk
   always_comb begin
      if (ctl.walk) begin
         rt_raddr = idx_ff;
      end else if (req_command == CMD_COUNT) begin
         rt_raddr = AW'(17'(req_row) + 17'd1);
      end else begin
         rt_raddr = AW'(req_pointer_index);
      end
      cur_raddr = CW'(req_row);
   end

   // range and capacity checks
   assign row_ok     = ({1'b0, row_ff} < rows_ff);
   assign total_full = (32'(total_ff) >= NNZ_MAX);
   assign dest_ok    = (cur_rdata_ff < total_ff) && (32'(cur_rdata_ff) < NNZ_MAX);
   assign pidx_ok    = (pidx_ff <= rows_ff);
   assign count_ok   = (cmd_ff == CMD_COUNT) && row_ok && !total_full;
   assign place_ok   = (cmd_ff == CMD_PLACE) && row_ok && dest_ok;
   assign walk_sum   = rt_rdata_ff + acc_ff;

   // memory writes
   always_comb begin
      rt_we     = 1'b0;
      rt_waddr  = idx_ff;
      rt_wdata  = '0;
      cur_we    = 1'b0;
      cur_waddr = CW'(row_ff);
      cur_wdata = cur_rdata_ff + 17'd1;
      if (ctl.sweep) begin
         rt_we = 1'b1;
      end else if (ctl.walk && pv_ff) begin
         rt_we     = 1'b1;
         rt_waddr  = pk_ff;
         rt_wdata  = walk_sum;
         cur_we    = (17'(pk_ff) < 17'(rows_ff));
         cur_waddr = CW'(pk_ff);
         cur_wdata = walk_sum;
      end else if (ctl.exec) begin
         if (count_ok) begin
            rt_we    = 1'b1;
            rt_waddr = AW'(17'(row_ff) + 17'd1);
            rt_wdata = rt_rdata_ff + 17'd1;
         end
         cur_we = place_ok;
      end
   end

   // result fields per command
   always_comb begin
      slot_in = '0;
      cout_in = '0;
      vout_in = '0;
      ptr_in  = '0;
      err_in  = 1'b0;
      case (cmd_ff)
         CMD_CLEAR: begin
         end
         CMD_FINALIZE: begin
            ptr_in = total_ff;
         end
         CMD_COUNT: begin
            err_in = !count_ok;
         end
         CMD_PLACE: begin
            if (place_ok) begin
               slot_in = cur_rdata_ff[15:0];
               cout_in = col_ff;
               vout_in = val_ff;
            end else begin
               err_in = 1'b1;
            end
         end
         CMD_READ: begin
            if (pidx_ok) begin
               ptr_in = rt_rdata_ff;
            end else begin
               err_in = 1'b1;
            end
         end
         default: begin
            err_in = 1'b1;
         end
      endcase
   end

   // next values of the control registers
   always_comb begin
      rows_in = rows_ff;
      if (csr_valid && csr_ready) begin
         if (csr_num_rows == 11'd0) begin
            rows_in = 11'd1;
         end else if (17'(csr_num_rows) > ROWS_MAX_W) begin
            rows_in = 11'(ROWS_MAX);
         end else begin
            rows_in = csr_num_rows;
         end
      end

      total_in = total_ff;
      if (ctl.sweep) begin
         total_in = '0;
      end else if (ctl.exec && count_ok) begin
         total_in = total_ff + 17'd1;
      end

      idx_in = idx_ff;
      pv_in  = pv_ff;
      acc_in = acc_ff;
      if (ctl.accept) begin
         idx_in = '0;
         pv_in  = 1'b0;
         acc_in = '0;
      end else if (ctl.sweep || ctl.walk) begin
         idx_in = idx_ff + AW'(1);
         if (ctl.walk) begin
            pv_in = 1'b1;
            if (pv_ff) begin
               acc_in = walk_sum;
            end
         end
      end
   end

   assign respond = ctl.exec || ctl.finish;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= ROWS_RESET;
         total_ff     <= '0;
         idx_ff       <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_ff      <= rows_in;
         total_ff     <= total_in;
         idx_ff       <= idx_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= respond;
      end
   end

   // request capture, walk pipeline and result registers
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (ctl.walk) begin
         pk_ff <= idx_ff;
      end
      if (ctl.accept) begin
         cmd_ff  <= req_command;
         row_ff  <= req_row;
         col_ff  <= req_col;
         val_ff  <= req_value;
         pidx_ff <= req_pointer_index;
      end
      if (respond) begin
         slot_ff <= slot_in;
         cout_ff <= cout_in;
         vout_ff <= vout_in;
         ptr_ff  <= ptr_in;
         err_ff  <= err_in;
      end
   end

   assign sts.sweep_last = (idx_ff == AW'(ROWS_MAX));
   assign sts.walk_done  = pv_ff && (17'(pk_ff) == 17'(rows_ff));

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_dest_slot   = slot_ff;
   assign rsp_col_out     = cout_ff;
   assign rsp_value_out   = vout_ff;
   assign rsp_row_pointer = ptr_ff;
   assign rsp_error       = err_ff;

   // checks
   `ASSERT_NEXT(a_rsp_follows, clock, reset, respond, rsp_valid_ff)
   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid_ff, !rsp_valid_ff)
   `ASSERT_NEXT(a_sweep_total, clock, reset, ctl.sweep, total_ff == 17'd0)

endmodule

// ===== hw/rtl/coo_to_csr_converter_top.sv =====
// count, place, read and unknown commands: exec state, then registered result strobe
// clear: row table sweep over ROWS_MAX+1 entries, one write per cycle, result in the next cycle
// finalize: prefix walk over num_rows+1 entries through one read port
// reset: synchronous; afterwards busy stays high for the whole row table sweep
// results are one-cycle strobes; the receiver cannot stall
`timescale 1ns / 1ps

module coo_to_csr_converter_top import coo2csr_pkg::*; #(
   parameter int ROWS_MAX = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_command,
   input  logic [9:0]  req_row,
   input  logic [30:0] req_col,
   input  logic [31:0] req_value,
   input  logic [10:0] req_pointer_index,
   output logic        rsp_valid,
   output logic [15:0] rsp_dest_slot,
   output logic [30:0] rsp_col_out,
   output logic [31:0] rsp_value_out,
   output logic [16:0] rsp_row_pointer,
   output logic        rsp_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_num_rows
);

   ctl_type ctl;
   sts_type sts;

   // sequencer
   coo2csr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .sts         (sts),
      .ctl         (ctl),
      .busy        (busy)
   );

   // tables, counters and result registers
   coo2csr_datapath #(
      .ROWS_MAX (ROWS_MAX)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .req_command       (req_command),
      .req_row           (req_row),
      .req_col           (req_col),
      .req_value         (req_value),
      .req_pointer_index (req_pointer_index),
      .rsp_valid         (rsp_valid),
      .rsp_dest_slot     (rsp_dest_slot),
      .rsp_col_out       (rsp_col_out),
      .rsp_value_out     (rsp_value_out),
      .rsp_row_pointer   (rsp_row_pointer),
      .rsp_error         (rsp_error),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_num_rows      (csr_num_rows)
   );

endmodule

// ===== tb/coo_to_csr_checker.sv =====
`timescale 1ns / 1ps

module coo_to_csr_checker import coo2csr_pkg::*; #(
   parameter int ROWS_MAX = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [2:0]  req_command,
   input  logic [9:0]  req_row,
   input  logic [30:0] req_col,
   input  logic [31:0] req_value,
   input  logic [10:0] req_pointer_index,
   input  logic        rsp_valid,
   input  logic [15:0] rsp_dest_slot,
   input  logic [30:0] rsp_col_out,
   input  logic [31:0] rsp_value_out,
   input  logic [16:0] rsp_row_pointer,
   input  logic        rsp_error,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [10:0] csr_num_rows,
   output int          pending,
   output int          failures
);

   typedef struct packed {
      logic [15:0] dest_slot;
      logic [30:0] col_out;
      logic [31:0] value_out;
      logic [16:0] row_pointer;
      logic        error;
   } csr_result_type;

   // shadow copy of the converter state
   logic [10:0] row_count_reg;
   logic [16:0] row_table [0:ROWS_MAX];
   logic [16:0] slot_cursor [0:ROWS_MAX-1];
   logic [16:0] entry_total;
   csr_result_type results_due [$];

   // register value clamped to the supported range
   function automatic int unsigned rows_in_effect();
      if (row_count_reg == 0)
         return 1;
      if (row_count_reg > ROWS_MAX)
         return ROWS_MAX;
      return 32'(row_count_reg);
   endfunction

   function automatic void clear_row_table();
      for (int i = 0; i <= ROWS_MAX; i++)
         row_table[i] = '0;
      entry_total = '0;
   endfunction

   // apply one command to the shadow state and return the result it produces
   function automatic csr_result_type advance_converter(logic [2:0] cmd, logic [9:0] row,
                                                        logic [30:0] col, logic [31:0] value,
                                                        logic [10:0] pidx);
      csr_result_type res;
      int unsigned nr;
      logic [16:0] dest;
      res = '0;
      nr = rows_in_effect();
      case (cmd)
         CMD_CLEAR: begin
            clear_row_table();
         end
         CMD_COUNT: begin
            if (int'(row) >= nr || entry_total >= NNZ_MAX) begin
               res.error = 1'b1;
            end else begin
               row_table[int'(row) + 1] = row_table[int'(row) + 1] + 17'd1;
               entry_total = entry_total + 17'd1;
            end
         end
         CMD_FINALIZE: begin
            // running sum turns the histogram into row pointers
            for (int i = 0; i < nr; i++)
               row_table[i + 1] = row_table[i + 1] + row_table[i];
            for (int i = 0; i < nr; i++)
               slot_cursor[i] = row_table[i];
            res.row_pointer = entry_total;
         end
         CMD_PLACE: begin
            if (int'(row) >= nr) begin
               res.error = 1'b1;
            end else begin
               dest = slot_cursor[row];
               if (dest >= entry_total || dest >= NNZ_MAX) begin
                  res.error = 1'b1;
               end else begin
                  res.dest_slot = dest[15:0];
                  res.col_out = col;
                  res.value_out = value;
                  slot_cursor[row] = dest + 17'd1;
               end
            end
         end
         CMD_READ: begin
            if (int'(pidx) > nr)
               res.error = 1'b1;
            else
               res.row_pointer = row_table[pidx];
         end
         default: begin
            res.error = 1'b1;
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      csr_result_type seen;
      csr_result_type due;
      if (reset) begin
         clear_row_table();
         for (int i = 0; i < ROWS_MAX; i++)
            slot_cursor[i] = '0;
         row_count_reg = 11'd1024;
         results_due.delete();
      end else begin
         // result transfer: compare with the oldest expectation
         if (rsp_valid) begin
            seen = {rsp_dest_slot, rsp_col_out, rsp_value_out, rsp_row_pointer, rsp_error};
            if (results_due.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("%0t: result with nothing outstanding: %s%0d %h %h %0d %0b",
                           $time, "slot col value ptr err = ", seen.dest_slot,
                           seen.col_out, seen.value_out, seen.row_pointer, seen.error);
            end else begin
               due = results_due.pop_front();
               if (seen !== due) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("%0t: mismatch: expected slot=%0d col=%h value=%h ptr=%0d err=%0b",
                              $time, due.dest_slot, due.col_out, due.value_out,
                              due.row_pointer, due.error);
                     $display("%0t: mismatch: actual   slot=%0d col=%h value=%h ptr=%0d err=%0b",
                              $time, seen.dest_slot, seen.col_out, seen.value_out,
                              seen.row_pointer, seen.error);
                  end
               end
            end
         end
         // register write transfer
         if (csr_valid && csr_ready)
            row_count_reg = csr_num_rows;
         // command transfer
         if (start && !busy)
            results_due.push_back(advance_converter(req_command, req_row, req_col, req_value,
                                                    req_pointer_index));
      end
      pending <= results_due.size();
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import coo2csr_pkg::*;

   localparam int ROWS_MAX = 1024;
   localparam int RANDOM_ITEMS = 600;
   localparam int SETTLE_CYCLES = 8;
   localparam realtime RUN_LIMIT = 4_800_000;

   // command codes the block does not define
   localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

   localparam logic [10:0] ROW_SETTINGS [8] = '{11'd1, 11'd0, 11'd2047, 11'd3,
                                                 11'd1024, 11'd17, 11'd1000, 11'd64};

   // sender gap patterns; the result side cannot stall
   typedef enum int {
      GAPS_NONE,
      GAPS_SENDER_HEAVY,
      GAPS_BOTH_LIGHT
   } gap_mode_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_command;
   logic [9:0]  req_row;
   logic [30:0] req_col;
   logic [31:0] req_value;
   logic [10:0] req_pointer_index;
   logic        rsp_valid;
   logic [15:0] rsp_dest_slot;
   logic [30:0] rsp_col_out;
   logic [31:0] rsp_value_out;
   logic [16:0] rsp_row_pointer;
   logic        rsp_error;
   logic        csr_valid;
   logic        csr_ready;
   logic [10:0] csr_num_rows;
   int          pending;
   int          failures;

   gap_mode_type gap_mode;
   int unsigned  rows_now;
   int           random_items;

   coo_to_csr_converter_top #(.ROWS_MAX(ROWS_MAX)) uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_row           (req_row),
      .req_col           (req_col),
      .req_value         (req_value),
      .req_pointer_index (req_pointer_index),
      .rsp_valid         (rsp_valid),
      .rsp_dest_slot     (rsp_dest_slot),
      .rsp_col_out       (rsp_col_out),
      .rsp_value_out     (rsp_value_out),
      .rsp_row_pointer   (rsp_row_pointer),
      .rsp_error         (rsp_error),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_num_rows      (csr_num_rows)
   );

   coo_to_csr_checker #(.ROWS_MAX(ROWS_MAX)) conv_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_row           (req_row),
      .req_col           (req_col),
      .req_value         (req_value),
      .req_pointer_index (req_pointer_index),
      .rsp_valid         (rsp_valid),
      .rsp_dest_slot     (rsp_dest_slot),
      .rsp_col_out       (rsp_col_out),
      .rsp_value_out     (rsp_value_out),
      .rsp_row_pointer   (rsp_row_pointer),
      .rsp_error         (rsp_error),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_num_rows      (csr_num_rows),
      .pending           (pending),
      .failures          (failures)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #(RUN_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   // idle cycles before the next command transfer
   function automatic int pick_gap();
      case (gap_mode)
         GAPS_SENDER_HEAVY: return $urandom_range(0, 99) < 15 ? 0 : $urandom_range(2, 26);
         GAPS_BOTH_LIGHT:   return $urandom_range(0, 99) < 11 ? $urandom_range(1, 2) : 0;
         default:           return 0;
      endcase
   endfunction

   // one command transfer; start stays high for back-to-back commands
   task automatic issue(input logic [2:0] cmd, input logic [9:0] row, input logic [30:0] col,
                        input logic [31:0] value, input logic [10:0] pidx);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_row <= row;
      req_col <= col;
      req_value <= value;
      req_pointer_index <= pidx;
      do @(posedge clock); while (busy);
      random_items++;
   endtask

   // drain all results, then write the row count register
   task automatic write_row_count(input logic [10:0] n);
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_num_rows <= n;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      rows_now = (n == 0) ? 1 : (n > ROWS_MAX) ? ROWS_MAX : n;
   endtask

   // a row mostly inside the active range, sometimes past it
   function automatic logic [9:0] pick_row(int unsigned span);
      if (rows_now < ROWS_MAX && $urandom_range(0, 99) < 6)
         return 10'($urandom_range(rows_now, ROWS_MAX - 1));
      return 10'($urandom_range(0, span - 1));
   endfunction

   // full conversion: clear, count pass, finalize, place pass, pointer reads
   task automatic convert_matrix(input int nnz, input int unsigned span);
      logic [9:0] entry_rows [$];
      logic [9:0] r;
      issue(CMD_CLEAR, 10'($urandom()), 31'($urandom()), $urandom(), 11'($urandom()));
      for (int k = 0; k < nnz; k++) begin
         r = pick_row(span);
         entry_rows.push_back(r);
         issue(CMD_COUNT, r, 31'($urandom()), $urandom(), 11'($urandom()));
      end
      issue(CMD_FINALIZE, 10'($urandom()), 31'($urandom()), $urandom(), 11'($urandom()));
      entry_rows.shuffle();
      foreach (entry_rows[k])
         issue(CMD_PLACE, entry_rows[k], 31'($urandom()), $urandom(), 11'($urandom()));
      // extra places run into exhausted cursors
      repeat ($urandom_range(0, 2))
         issue(CMD_PLACE, pick_row(span), 31'($urandom()), $urandom(), 11'($urandom()));
      repeat ($urandom_range(2, 5))
         issue(CMD_READ, 10'($urandom()), 31'($urandom()), $urandom(),
               11'($urandom_range(0, rows_now + 1)));
   endtask

   // arbitrary command mix
   task automatic issue_noise(input int n);
      int pick;
      logic [2:0] cmd;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 3)
            cmd = CMD_CLEAR;
         else if (pick < 6)
            cmd = CMD_FINALIZE;
         else if (pick < 40)
            cmd = CMD_COUNT;
         else if (pick < 70)
            cmd = CMD_PLACE;
         else if (pick < 90)
            cmd = CMD_READ;
         else
            cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
         issue(cmd, 10'($urandom()), 31'($urandom()), $urandom(), 11'($urandom()));
      end
   endtask

   // stimulus
   initial begin
      int phase;
      reset <= 1'b1;
      start <= 1'b0;
      req_command <= CMD_CLEAR;
      req_row <= '0;
      req_col <= '0;
      req_value <= '0;
      req_pointer_index <= '0;
      csr_valid <= 1'b0;
      csr_num_rows <= '0;
      gap_mode = GAPS_NONE;
      rows_now = ROWS_MAX;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: pointer reads at the range edges on the cleared table
      issue(CMD_READ, '0, '0, '0, 11'd0);
      issue(CMD_READ, '0, '0, '0, 11'd1024);
      issue(CMD_READ, '0, '0, '0, 11'd1025);
      issue(CMD_READ, '0, '0, '0, 11'h7ff);
      // small matrix over rows 0, 5 and 1023; the full-range finalize sets every cursor
      issue(CMD_CLEAR, '0, '0, '0, '0);
      issue(CMD_COUNT, 10'd0, 31'($urandom()), $urandom(), 11'($urandom()));
      issue(CMD_COUNT, 10'd1023, 31'($urandom()), $urandom(), 11'($urandom()));
      issue(CMD_COUNT, 10'd1023, 31'($urandom()), $urandom(), 11'($urandom()));
      issue(CMD_COUNT, 10'd5, 31'($urandom()), $urandom(), 11'($urandom()));
      for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++)
         issue(3'(c), 10'($urandom()), 31'($urandom()), $urandom(), 11'($urandom()));
      issue(CMD_FINALIZE, '0, '0, '0, '0);
      issue(CMD_PLACE, 10'd0, '0, '0, '0);
      issue(CMD_PLACE, 10'd1023, 31'h7fffffff, 32'hffffffff, 11'h7ff);
      issue(CMD_PLACE, 10'd1023, 31'($urandom()), $urandom(), 11'($urandom()));
      // last row already full: place overflow
      issue(CMD_PLACE, 10'd1023, 31'($urandom()), $urandom(), 11'($urandom()));
      issue(CMD_PLACE, 10'd5, 31'($urandom()), $urandom(), 11'($urandom()));
      // repeated finalize sums the pointers again
      issue(CMD_FINALIZE, '0, '0, '0, '0);
      issue(CMD_READ, '0, '0, '0, 11'd1024);
      issue(CMD_READ, '0, '0, '0, 11'd1);
      issue(CMD_CLEAR, '0, '0, '0, '0);

      // random phases over row counts and gap patterns
      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         write_row_count(phase < 8 ? ROW_SETTINGS[phase] : 11'($urandom_range(0, 2047)));
         gap_mode = gap_mode_type'(phase % 3);
         repeat (2) begin
            if ($urandom_range(0, 9) == 0)
               convert_matrix($urandom_range(60, 120), rows_now < 3 ? rows_now : 3);
            else
               convert_matrix($urandom_range(1, 30),
                              $urandom_range(0, 1) ? rows_now : (rows_now < 8 ? rows_now : 8));
         end
         issue_noise(15);
         phase++;
      end

      // drain and give the verdict
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/coo2csr_pkg.sv
hw/rtl/coo2csr_ctrl.sv
hw/rtl/coo2csr_datapath.sv
hw/rtl/coo_to_csr_converter_top.sv
tb/coo_to_csr_checker.sv
tb/tb.sv
